// ===== design/mcufp_pkg.sv =====
// ----------------------------------------------------------------------------
// mcufp_pkg: shared types and constants of the UART frame poller
// Beat layouts, action codes, channel phases and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package mcufp_pkg;

  localparam int CHANNELS_DEFAULT = 8;
  localparam int FRAME_BYTES      = 8;
  localparam int BYTE_IDX_W       = $clog2(FRAME_BYTES);
  localparam int COUNT_W          = 4;
  localparam int REG_ADDR_W       = 3;
  localparam int APB_DATA_W       = 32;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_POLL  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_SEND  = 2'd1,
    ACT_POP   = 2'd2,
    ACT_FRAME = 2'd3
  } action_t;

  typedef enum logic [4:0] {
    PH_DISABLED = 5'b00001,
    PH_IDLE     = 5'b00010,
    PH_WAIT_TX  = 5'b00100,
    PH_WAIT_RX  = 5'b01000,
    PH_VALID    = 5'b10000
  } phase_t;

  typedef enum logic {
    REG_CHANNEL_ENABLE = 1'b0,
    REG_REQUEST_BYTE   = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic       func;
    logic [2:0] channel;
    logic       tx_empty;
    logic       rx_valid;
    logic [7:0] rx_byte;
  } poll_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  out_channel;
    logic [7:0]  command_byte;
    logic [7:0]  driver_enable;
    logic [63:0] frame_word;
    logic        round_done;
  } result_item_t;

  typedef struct packed {
    logic [7:0] request_byte;
    logic [7:0] channel_enable;
  } cfg_t;

endpackage

`default_nettype wire

// ===== design/mcufp_cfg.sv =====
// ----------------------------------------------------------------------------
// mcufp_cfg: configuration registers
// APB-style write and read of the channel enable mask and the request byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mcufp_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [mcufp_pkg::REG_ADDR_W-1:0]    paddr,
  input  wire logic [mcufp_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [mcufp_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                     pready,
  output mcufp_pkg::cfg_t                          cfg
);

  mcufp_pkg::reg_index_t index;
  logic                  wr_en;

  // Registers sit on 32-bit word addresses.
  assign index  = mcufp_pkg::reg_index_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (index)
        mcufp_pkg::REG_CHANNEL_ENABLE: cfg.channel_enable <= pwdata[7:0];
        mcufp_pkg::REG_REQUEST_BYTE:   cfg.request_byte   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (index)
      mcufp_pkg::REG_CHANNEL_ENABLE: prdata = {24'd0, cfg.channel_enable};
      mcufp_pkg::REG_REQUEST_BYTE:   prdata = {24'd0, cfg.request_byte};
      default:                       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/mcufp_engine.sv =====
// ----------------------------------------------------------------------------
// mcufp_engine: per-channel poll sequencer
// Holds channel phases, byte counts, frame bytes and masks; computes one
// result per beat and commits the new state when the beat fires.
// ----------------------------------------------------------------------------
`default_nettype none

module mcufp_engine #(
  parameter int CHANNELS = mcufp_pkg::CHANNELS_DEFAULT
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    fire,
  input  wire mcufp_pkg::poll_item_t   item,
  input  wire mcufp_pkg::cfg_t         cfg,
  output mcufp_pkg::result_item_t      result
);

  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PAD_W   = (CHANNELS > 8) ? CHANNELS : 8;
  localparam int FRAME_W = 8 * mcufp_pkg::FRAME_BYTES;

  mcufp_pkg::phase_t                 phase      [CHANNELS];
  mcufp_pkg::phase_t                 phase_next [CHANNELS];
  logic [mcufp_pkg::COUNT_W-1:0]     count      [CHANNELS];
  logic [mcufp_pkg::COUNT_W-1:0]     count_next [CHANNELS];
  // One frame word per channel; each received byte lands in its own lane.
  logic [FRAME_W-1:0]                frame      [CHANNELS];
  logic [CHANNELS-1:0]               busy, busy_next;
  logic [CHANNELS-1:0]               drive, drive_next;
  logic [CHANNELS-1:0]               start_mask;
  logic [PAD_W-1:0]                  drive_pad;
  logic [CH_W-1:0]                   sel;
  logic                              in_range;
  logic                              hit;
  logic                              byte_we;
  logic [mcufp_pkg::COUNT_W-1:0]     n;
  mcufp_pkg::action_t                act;
  logic [63:0]                       frame_word;

  assign sel        = CH_W'(item.channel);
  assign in_range   = 32'(item.channel) < CHANNELS;
  assign hit        = in_range && busy[sel];
  assign n          = count[sel];
  assign start_mask = CHANNELS'(cfg.channel_enable);

  always_comb begin
    phase_next = phase;
    count_next = count;
    busy_next  = busy;
    drive_next = drive;
    byte_we    = 1'b0;
    act        = mcufp_pkg::ACT_NONE;
    frame_word = '0;
    if (item.func == mcufp_pkg::FUNC_START) begin
      for (int i = 0; i < CHANNELS; i++) begin
        phase_next[i] = start_mask[i] ? mcufp_pkg::PH_IDLE : mcufp_pkg::PH_DISABLED;
        count_next[i] = '0;
      end
      busy_next  = start_mask;
      drive_next = '0;
    end else if (hit) begin
      unique case (phase[sel])
        mcufp_pkg::PH_IDLE: begin
          act             = mcufp_pkg::ACT_SEND;
          drive_next[sel] = 1'b1;
          phase_next[sel] = mcufp_pkg::PH_WAIT_TX;
        end
        mcufp_pkg::PH_WAIT_TX: begin
          if (item.tx_empty) begin
            drive_next[sel] = 1'b0;
            phase_next[sel] = mcufp_pkg::PH_WAIT_RX;
          end
        end
        mcufp_pkg::PH_WAIT_RX: begin
          if (item.rx_valid) begin
            act = mcufp_pkg::ACT_POP;
            // The byte after the eighth is the check byte and is dropped.
            if (n < mcufp_pkg::COUNT_W'(mcufp_pkg::FRAME_BYTES)) begin
              byte_we = 1'b1;
            end else begin
              phase_next[sel] = mcufp_pkg::PH_VALID;
            end
            if (n != '1) begin
              count_next[sel] = n + 1'b1;
            end
          end
        end
        mcufp_pkg::PH_VALID: begin
          act             = mcufp_pkg::ACT_FRAME;
          frame_word      = frame[sel];
          phase_next[sel] = mcufp_pkg::PH_IDLE;
          busy_next[sel]  = 1'b0;
        end
        default: begin
          busy_next[sel] = 1'b0;
        end
      endcase
    end
  end

  assign drive_pad = PAD_W'(drive_next);

  always_comb begin
    result.action        = act;
    result.out_channel   = item.channel;
    result.command_byte  = (act == mcufp_pkg::ACT_SEND) ? cfg.request_byte : 8'd0;
    result.driver_enable = drive_pad[7:0];
    result.frame_word    = frame_word;
    result.round_done    = (busy_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        phase[i] <= mcufp_pkg::PH_DISABLED;
        count[i] <= '0;
      end
      busy  <= '0;
      drive <= '0;
    end else if (fire) begin
      phase <= phase_next;
      count <= count_next;
      busy  <= busy_next;
      drive <= drive_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && byte_we) begin
      frame[sel][{n[mcufp_pkg::BYTE_IDX_W-1:0], 3'b000} +: 8] <= item.rx_byte;
    end
  end

endmodule

`default_nettype wire

// ===== design/multi_channel_uart_frame_poller_core.sv =====
// ----------------------------------------------------------------------------
// multi_channel_uart_frame_poller_core: UART frame poller top level
// Input register, poll sequencer, result register and configuration port.
// ----------------------------------------------------------------------------
// Usage:
//   Poll beats enter on poll_valid / poll_stall / poll_item; results leave on
//   result_valid / result_stall / result_item, exactly one result per poll
//   beat and in the same order. A beat with func start opens a round using
//   the channel_enable register; poll beats then step one channel each.
//   A beat is captured in the input register, processed there by the sequencer
//   and registered in the result register. Throughput is one beat per cycle
//   while result_stall holds no waiting result, set by the state update
//   of the sequencer between the input and result registers.
//   When result_stall holds a waiting result, the input register still takes
//   one more beat; after that poll_stall rises until the result is taken.
//   Reset (rst, synchronous) empties both registers, sets every channel to
//   disabled, clears byte counts, busy and driver enable bits, and clears the
//   configuration registers. No clearing pass is needed. Configuration must be
//   written via the APB-style port only while idle; the core does not check it.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_uart_frame_poller_core #(
  parameter int CHANNELS = mcufp_pkg::CHANNELS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              poll_valid,
  output logic                                   poll_stall,
  input  wire mcufp_pkg::poll_item_t             poll_item,
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output mcufp_pkg::result_item_t                result_item,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [mcufp_pkg::REG_ADDR_W-1:0]  paddr,
  input  wire logic [mcufp_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [mcufp_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                   pready
);

  mcufp_pkg::cfg_t         cfg;
  mcufp_pkg::poll_item_t   hold_item;
  mcufp_pkg::result_item_t eng_result;
  logic                    hold_valid;
  logic                    advance;
  logic                    fire;

  assign advance    = !result_valid || !result_stall;
  assign fire       = hold_valid && advance;
  assign poll_stall = hold_valid && !advance;

  mcufp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mcufp_engine #(
    .CHANNELS (CHANNELS)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (hold_item),
    .cfg    (cfg),
    .result (eng_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!poll_stall) begin
      hold_valid <= poll_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll_valid && !poll_stall) begin
      hold_item <= poll_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_item <= eng_result;
    end
  end

endmodule

`default_nettype wire

// ===== design/mcufp_checker.sv =====
// ----------------------------------------------------------------------------
// mcufp_checker: port-level assertions for the UART frame poller
// Watches the poll and result channels of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module mcufp_checker (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    poll_stall,
  input wire logic                    result_valid,
  input wire logic                    result_stall,
  input wire mcufp_pkg::result_item_t result_item
);

  // Reset leaves no result pending and the input open.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !poll_stall)
    else $error("result pending or input stalled after reset");

  // A stalled result beat stays offered and unchanged.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_item))
    else $error("stalled result beat changed or dropped");

  // With the result register empty the input never back-pressures.
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !poll_stall)
    else $error("poll stalled while result register is empty");

  // A request send always leaves that channel's driver enabled.
  a_send_drives: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_item.action == mcufp_pkg::ACT_SEND)
      |-> result_item.driver_enable[result_item.out_channel])
    else $error("request sent without driver enable");

endmodule

bind multi_channel_uart_frame_poller_core mcufp_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .poll_stall   (poll_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_item  (result_item)
);

`default_nettype wire
